FILE: src/xrg_pkg.sv
// shared types, constants and helpers for the xoroshiro range generator
`timescale 1ns / 1ps

package xrg_pkg;

  localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

  localparam int unsigned ROT_A   = 55;
  localparam int unsigned SHIFT_B = 14;
  localparam int unsigned ROT_C   = 36;
  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  localparam logic [1:0] WIDTH_64 = 2'd0;
  localparam logic [1:0] WIDTH_32 = 2'd1;
  localparam logic [1:0] WIDTH_16 = 2'd2;
  localparam logic [1:0] WIDTH_8  = 2'd3;

  typedef struct packed {
    logic [1:0]  width_select;
    logic        ranged;
    logic [63:0] low_bound;
    logic [63:0] high_bound;
  } in_item_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic        state_advanced;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    S_MIX_ADD,
    S_MUL1_GO,
    S_MUL1_WAIT,
    S_MUL2_GO,
    S_MUL2_WAIT,
    S_MIX_OUT,
    S_IDLE,
    S_EVAL,
    S_DIV_WAIT,
    S_FINISH
  } fsm_e;

  function automatic logic [63:0] width_mask(input logic [1:0] sel);
    logic [63:0] m;
    case (sel)
      WIDTH_64: m = '1;
      WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
      WIDTH_16: m = 64'h0000_0000_0000_FFFF;
      WIDTH_8:  m = 64'h0000_0000_0000_00FF;
      default:  m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] top_bits(input logic [63:0] v, input logic [1:0] sel);
    logic [63:0] r;
    case (sel)
      WIDTH_64: r = v;
      WIDTH_32: r = v >> 32;
      WIDTH_16: r = v >> 48;
      WIDTH_8:  r = v >> 56;
      default:  r = v;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

endpackage

FILE: src/xrg_mul.sv
// shared 64x64 multiplier, low product half, one 32x32 partial product per cycle
`timescale 1ns / 1ps

module xrg_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [63:0]       product_o
);
  import xrg_pkg::*;

  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] pa, pb;
  logic [63:0] prod;

  always_comb begin
    case (cnt_q)
      2'd0: begin
        pa = a_q[31:0];
        pb = b_q[31:0];
      end
      2'd1: begin
        pa = a_q[31:0];
        pb = b_q[63:32];
      end
      default: begin
        pa = a_q[63:32];
        pb = b_q[31:0];
      end
    endcase
    prod = {32'd0, pa} * {32'd0, pb};
  end

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      a_d    = req_i.op_a;
      b_d    = req_i.op_b;
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d = acc_q + {prod[31:0], 32'd0};
      end
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

FILE: src/xrg_div.sv
// bit-serial 64-bit remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module xrg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xrg_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [63:0]       rem_o
);
  import xrg_pkg::*;

  logic [63:0] rem_q, rem_d, dvd_q, dvd_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [64:0] trial, diff;

  always_comb begin
    trial  = {rem_q, dvd_q[63]};
    diff   = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = diff[64] ? trial[63:0] : diff[63:0];
      dvd_d = {dvd_q[62:0], 1'b0};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

FILE: src/xoroshiro_range_generator_top.sv
// top level of the xoroshiro128+ range generator
`timescale 1ns / 1ps

// xoroshiro128+ generator (rotations 55/14/36) with plain and bounded draws at
// 64, 32, 16 or 8 bits. One item at a time: a plain draw or an empty range is
// evaluated directly and then finished; a bounded draw waits on the bit-serial
// remainder unit, which handles one dividend bit per cycle. After reset and after
// every seed write the two state words are rebuilt through the splitmix mix on a
// shared 32x32 multiplier (three partial products per 64-bit multiply, two
// multiplies per word); no item and no seed write is taken meanwhile. A finished
// result may wait on the output while the next item is taken.

module xoroshiro_range_generator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  xrg_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xrg_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [63:0]        cfg_data_i
);
  import xrg_pkg::*;

  fsm_e        state_q, state_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] sa_q, sa_d, sb_q, sb_d;
  logic [63:0] z_q, z_d;
  logic        word_b_q, word_b_d;
  in_item_t    req_q, req_d;
  out_item_t   res_q, res_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  mul_req_t    mul_req;
  logic        mul_done;
  logic [63:0] mul_prod;
  div_req_t    div_req;
  logic        div_done;
  logic [63:0] div_rem;

  logic        in_acc, cfg_acc, slot_free;
  logic [63:0] mask, lo_m, hi_m, sum, bx;

  xrg_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mul_req),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  xrg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .rem_o  (div_rem)
  );

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = !((state_q == S_IDLE) && !cfg_valid_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;

  assign mask = width_mask(req_q.width_select);
  assign lo_m = req_q.low_bound & mask;
  assign hi_m = req_q.high_bound & mask;
  assign sum  = sa_q + sb_q;
  assign bx   = sb_q ^ sa_q;

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    z_d         = z_q;
    word_b_d    = word_b_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_req     = '{start: 1'b0, op_a: z_q, op_b: MIX_MUL_A};
    div_req     = '{start: 1'b0, dividend: sum, divisor: hi_m - lo_m};

    case (state_q)
      S_MIX_ADD: begin
        z_d     = (word_b_q ? seed_q + 64'd1 : seed_q) + GOLDEN_INC;
        state_d = S_MUL1_GO;
      end
      S_MUL1_GO: begin
        mul_req = '{start: 1'b1, op_a: z_q ^ (z_q >> MIX_SH1), op_b: MIX_MUL_A};
        state_d = S_MUL1_WAIT;
      end
      S_MUL1_WAIT: begin
        if (mul_done) begin
          z_d     = mul_prod;
          state_d = S_MUL2_GO;
        end
      end
      S_MUL2_GO: begin
        mul_req = '{start: 1'b1, op_a: z_q ^ (z_q >> MIX_SH2), op_b: MIX_MUL_B};
        state_d = S_MUL2_WAIT;
      end
      S_MUL2_WAIT: begin
        if (mul_done) begin
          z_d     = mul_prod;
          state_d = S_MIX_OUT;
        end
      end
      S_MIX_OUT: begin
        if (!word_b_q) begin
          sa_d     = z_q ^ (z_q >> MIX_SH3);
          word_b_d = 1'b1;
          state_d  = S_MIX_ADD;
        end else begin
          sb_d     = z_q ^ (z_q >> MIX_SH3);
          word_b_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_acc) begin
          seed_d   = cfg_data_i;
          word_b_d = 1'b0;
          state_d  = S_MIX_ADD;
        end else if (in_acc) begin
          req_d   = in_item_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (req_q.ranged && (hi_m <= lo_m)) begin
          res_d   = '{random_value: lo_m, state_advanced: 1'b0};
          state_d = S_FINISH;
        end else begin
          // advance the generator
          sa_d = rotl(sa_q, ROT_A) ^ bx ^ (bx << SHIFT_B);
          sb_d = rotl(bx, ROT_C);
          if (req_q.ranged) begin
            div_req.start = 1'b1;
            state_d       = S_DIV_WAIT;
          end else begin
            res_d   = '{random_value: top_bits(sum, req_q.width_select) & mask,
                        state_advanced: 1'b1};
            state_d = S_FINISH;
          end
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          res_d   = '{random_value: (div_rem + lo_m) & mask, state_advanced: 1'b1};
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_MIX_ADD;
      seed_q      <= '0;
      word_b_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      word_b_q    <= word_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    z_q   <= z_d;
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_item_to_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EVAL)
    else $error("accepted item did not reach evaluation");

  a_cfg_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc |=> state_q == S_MIX_ADD && !word_b_q)
    else $error("seed write did not start reseeding");

  a_empty_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && req_q.ranged && hi_m <= lo_m) |=> $stable(sa_q) && $stable(sb_q))
    else $error("empty range moved the state");

  a_mul_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL1_WAIT || state_q == S_MUL2_WAIT)
    else $error("multiplier finished outside a wait state");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("remainder unit finished outside its wait state");

endmodule
